>>> rtl/ukvt_pkg.sv
// ----------------------------------------------------------------------------
// ukvt_pkg - shared definitions of the unique key/value table
// Table sizes, command and status codes, the structs between the
// sequencer and the slot store, and the result struct.
// ----------------------------------------------------------------------------
package ukvt_pkg;

	localparam int ENTRIES     = 16;
	localparam int KEY_WIDTH   = 32;
	localparam int VALUE_WIDTH = 8;
	localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W       = $clog2(ENTRIES + 1);
	localparam int CMD_W       = 2;
	localparam int STATUS_W    = 2;

	typedef logic signed [KEY_WIDTH-1:0] key_t;
	typedef logic [VALUE_WIDTH-1:0]      value_t;
	typedef logic [IDX_W-1:0]            idx_t;
	typedef logic [CNT_W-1:0]            cnt_t;
	typedef logic [CMD_W-1:0]            cmd_t;
	typedef logic [STATUS_W-1:0]         status_t;

	localparam cmd_t CMD_INSERT = 2'd0;
	localparam cmd_t CMD_LOOKUP = 2'd1;
	localparam cmd_t CMD_DELETE = 2'd2;

	localparam status_t STATUS_OK        = 2'd0;
	localparam status_t STATUS_DUP       = 2'd1;
	localparam status_t STATUS_NOT_FOUND = 2'd2;
	localparam status_t STATUS_FULL      = 2'd3;

	// write-back request from the sequencer to the store
	typedef struct packed {
		logic   set_valid;
		logic   clr_valid;
		idx_t   idx;
		key_t   key;
		value_t value;
	} wr_req_t;

	// slot state seen by the sequencer
	typedef struct packed {
		logic [ENTRIES-1:0] valid;
		cnt_t               count;
		key_t               rd_key;
		value_t             rd_value;
	} store_rsp_t;

	// one finished result
	typedef struct packed {
		status_t status;
		value_t  found_value;
		cnt_t    entry_count;
	} result_t;

endpackage

>>> rtl/ukvt_store.sv
// ----------------------------------------------------------------------------
// ukvt_store - slot storage
// Key and value memories with one registered read port and one write port,
// plus the valid bits and the count of valid entries.
// ----------------------------------------------------------------------------
module ukvt_store (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ukvt_pkg::idx_t       rd_addr,
	input  ukvt_pkg::wr_req_t    wr,
	output ukvt_pkg::store_rsp_t rsp
);

	ukvt_pkg::key_t   key_mem   [ukvt_pkg::ENTRIES];
	ukvt_pkg::value_t value_mem [ukvt_pkg::ENTRIES];

	logic [ukvt_pkg::ENTRIES-1:0] valid_q;
	ukvt_pkg::cnt_t               count_q;
	ukvt_pkg::key_t               rd_key_q;
	ukvt_pkg::value_t             rd_value_q;

	always_ff @(posedge clk) begin
		if (wr.set_valid) begin
			key_mem[wr.idx]   <= wr.key;
			value_mem[wr.idx] <= wr.value;
		end
		rd_key_q   <= key_mem[rd_addr];
		rd_value_q <= value_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else begin
			if (wr.set_valid) begin
				valid_q[wr.idx] <= 1'b1;
				count_q         <= count_q + ukvt_pkg::cnt_t'(1);
			end else if (wr.clr_valid) begin
				valid_q[wr.idx] <= 1'b0;
				count_q         <= count_q - ukvt_pkg::cnt_t'(1);
			end
		end
	end

	assign rsp.valid    = valid_q;
	assign rsp.count    = count_q;
	assign rsp.rd_key   = rd_key_q;
	assign rsp.rd_value = rd_value_q;

endmodule

>>> rtl/ukvt_ctrl.sv
// ----------------------------------------------------------------------------
// ukvt_ctrl - scan sequencer
// Walks the slots one per cycle through a single key comparator, keeps the
// first hit and the lowest free slot, then decides and writes back.
// ----------------------------------------------------------------------------
module ukvt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ukvt_pkg::cmd_t       in_cmd,
	input  ukvt_pkg::key_t       in_key,
	input  ukvt_pkg::value_t     in_value,
	input  logic                 out_busy,
	output logic                 res_valid,
	output ukvt_pkg::result_t    res,
	output ukvt_pkg::idx_t       rd_addr,
	output ukvt_pkg::wr_req_t    wr,
	input  ukvt_pkg::store_rsp_t rsp
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_WB    = 2'd3;

	localparam ukvt_pkg::idx_t LAST_IDX = ukvt_pkg::idx_t'(ukvt_pkg::ENTRIES - 1);

	logic [1:0]       state_q;
	ukvt_pkg::idx_t   scan_q;
	ukvt_pkg::cmd_t   cmd_q;
	ukvt_pkg::key_t   key_q;
	ukvt_pkg::value_t value_q;
	logic             cmp_valid_s1;
	ukvt_pkg::idx_t   cmp_idx_s1;
	logic             hit_q;
	ukvt_pkg::idx_t   hit_idx_q;
	ukvt_pkg::value_t hit_value_q;
	logic             free_q;
	ukvt_pkg::idx_t   free_idx_q;

	logic slot_used;
	logic key_match;
	logic accept;

	assign in_ready  = (state_q == S_IDLE) && !out_busy;
	assign accept    = in_valid && in_ready;
	assign rd_addr   = scan_q;
	assign slot_used = rsp.valid[cmp_idx_s1];
	assign key_match = slot_used && (rsp.rd_key == key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmp_valid_s1 <= 1'b0;
			scan_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cmp_valid_s1 <= 1'b0;
					scan_q       <= '0;
					if (accept) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					cmp_valid_s1 <= 1'b1;
					scan_q       <= scan_q + ukvt_pkg::idx_t'(1);
					if (scan_q == LAST_IDX) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					cmp_valid_s1 <= 1'b0;
					state_q      <= S_WB;
				end
				S_WB: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= scan_q;
		if (accept) begin
			cmd_q   <= in_cmd;
			key_q   <= in_key;
			value_q <= in_value;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
		end else if (cmp_valid_s1) begin
			// keep the first match and the lowest free slot
			if (key_match && !hit_q) begin
				hit_q       <= 1'b1;
				hit_idx_q   <= cmp_idx_s1;
				hit_value_q <= rsp.rd_value;
			end
			if (!slot_used && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= cmp_idx_s1;
			end
		end
	end

	always_comb begin
		wr.set_valid    = 1'b0;
		wr.clr_valid    = 1'b0;
		wr.idx          = hit_idx_q;
		wr.key          = key_q;
		wr.value        = value_q;
		res.status      = ukvt_pkg::STATUS_OK;
		res.found_value = '0;
		res.entry_count = rsp.count;
		res_valid       = (state_q == S_WB);
		if (state_q == S_WB) begin
			unique case (cmd_q)
				ukvt_pkg::CMD_INSERT: begin
					if (hit_q) begin
						res.status = ukvt_pkg::STATUS_DUP;
					end else if (!free_q ||
						(rsp.count >= ukvt_pkg::cnt_t'(ukvt_pkg::ENTRIES))) begin
						res.status = ukvt_pkg::STATUS_FULL;
					end else begin
						wr.set_valid    = 1'b1;
						wr.idx          = free_idx_q;
						res.entry_count = rsp.count + ukvt_pkg::cnt_t'(1);
					end
				end
				ukvt_pkg::CMD_LOOKUP: begin
					if (hit_q) begin
						res.found_value = hit_value_q;
					end else begin
						res.status = ukvt_pkg::STATUS_NOT_FOUND;
					end
				end
				ukvt_pkg::CMD_DELETE: begin
					if (hit_q) begin
						wr.clr_valid    = 1'b1;
						res.entry_count = rsp.count - ukvt_pkg::cnt_t'(1);
					end else begin
						res.status = ukvt_pkg::STATUS_NOT_FOUND;
					end
				end
				default: begin
					// unused command: report ok, change nothing
					res.status = ukvt_pkg::STATUS_OK;
				end
			endcase
		end
	end

endmodule

>>> rtl/unique_key_value_table_core.sv
// ----------------------------------------------------------------------------
// unique_key_value_table_core - associative table with unique keys
// Holds up to 16 key/value pairs; each item inserts, looks up or deletes.
// ----------------------------------------------------------------------------
// Usage:
//   slave channel s_*: one command per item, s_tuser carries the command
//   (0 insert, 1 lookup, 2 delete), s_tdata the key and the value.
//   master channel m_*: one result per command, m_tuser carries the status
//   (0 ok, 1 duplicate, 2 not found, 3 full), m_tdata the value found by a
//   lookup and the entry count after the command.
// Timing: after an item is accepted, the sequencer scans the slots one per
//   cycle through the single key comparator, then waits for the registered
//   read of the last slot and then writes back; the write-back edge also
//   loads the output register and raises m_tvalid. s_tready stays low until the
//   cycle after the result is taken, so a new item is accepted only after the
//   previous result has left the output register.
// Reset: all slots become free and the count zero; the table is usable in
//   the first cycle after reset.
// Stall: a result waits in the output register while m_tready is low, and
//   no new item is accepted until it has been taken.
// ----------------------------------------------------------------------------
module unique_key_value_table_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // key[31:0], value[39:32]
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // found_value[7:0], entry_count[12:8], zero fill
	output logic [1:0]  m_tuser    // status[1:0]
);

	ukvt_pkg::idx_t       rd_addr;
	ukvt_pkg::wr_req_t    wr;
	ukvt_pkg::store_rsp_t rsp;
	ukvt_pkg::result_t    res;
	logic                 res_valid;
	logic                 out_valid_q;
	ukvt_pkg::result_t    out_q;

	ukvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.in_key    (s_tdata[ukvt_pkg::KEY_WIDTH-1:0]),
		.in_value  (s_tdata[ukvt_pkg::KEY_WIDTH +: ukvt_pkg::VALUE_WIDTH]),
		.out_busy  (out_valid_q),
		.res_valid (res_valid),
		.res       (res),
		.rd_addr   (rd_addr),
		.wr        (wr),
		.rsp       (rsp)
	);

	ukvt_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.wr      (wr),
		.rsp     (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (res_valid) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {3'b000, out_q.entry_count, out_q.found_value};

	// entry count never goes past the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.entry_count <= ukvt_pkg::cnt_t'(ukvt_pkg::ENTRIES)))
		else $error("entry count beyond table size");

	// a full status only when every slot is taken
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.status == ukvt_pkg::STATUS_FULL)) |->
		(out_q.entry_count == ukvt_pkg::cnt_t'(ukvt_pkg::ENTRIES)))
		else $error("full status with free slots");

	// found value is zero unless a lookup succeeded
	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.status != ukvt_pkg::STATUS_OK)) |->
		(out_q.found_value == '0))
		else $error("found value set on a failed command");

	// a result never appears in the cycle right after an item is taken
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !res_valid)
		else $error("result produced without a scan");

endmodule
